@@ rtl/pfs_pkg.sv @@
package pfs_pkg;

    // Fixed field widths.
    localparam int ACTION_W  = 2;
    localparam int CPU_W     = 2;
    localparam int OUTCOME_W = 3;
    localparam int VICTIM_W  = 2;
    localparam int CFG_W     = 3;

    localparam logic [CFG_W-1:0] ACTIVE_CPUS_RST = 3'd4;

    // Parameter defaults.
    localparam int NUM_CPUS_DEF       = 4;
    localparam int QUEUE_DEPTH_DEF    = 16;
    localparam int THREAD_ID_BITS_DEF = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_GET    = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [OUTCOME_W-1:0] {
        OC_QUEUED      = 3'd0,
        OC_IDLE_IGNORE = 3'd1,
        OC_DROPPED     = 3'd2,
        OC_PICKED      = 3'd3,
        OC_IDLE_PICKED = 3'd4,
        OC_TICK_DONE   = 3'd5
    } t_outcome;

    typedef enum logic [1:0] {
        Q_NOP,
        Q_PUSH,
        Q_POP
    } t_q_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SCAN,
        ST_POP,
        ST_RDATA,
        ST_OUT
    } t_state;

endpackage

@@ rtl/pfs_ram.sv @@
module pfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pfs_qtab.sv @@
module pfs_qtab #(
    parameter int NUM_CPUS    = pfs_pkg::NUM_CPUS_DEF,
    parameter int QUEUE_DEPTH = pfs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [$clog2(NUM_CPUS)-1:0]      i_sel,
    input  pfs_pkg::t_q_op                   i_op,
    output logic [$clog2(QUEUE_DEPTH)-1:0]   o_head,
    output logic [$clog2(QUEUE_DEPTH)-1:0]   o_tail,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [PW-1:0] r_head  [NUM_CPUS];
    logic [PW-1:0] r_tail  [NUM_CPUS];
    logic [CW-1:0] r_count [NUM_CPUS];

    // Ring pointers wrap at the depth, which need not be a power of two.
    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] ptr);
        logic [PW-1:0] res;
        if (ptr == PW'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + 1'b1;
        end
        return res;
    endfunction

    assign o_head  = r_head[i_sel];
    assign o_tail  = r_tail[i_sel];
    assign o_count = r_count[i_sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CPUS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            unique case (i_op)
                pfs_pkg::Q_PUSH: begin
                    r_tail[i_sel]  <= wrap_inc(r_tail[i_sel]);
                    r_count[i_sel] <= r_count[i_sel] + 1'b1;
                end
                pfs_pkg::Q_POP: begin
                    r_head[i_sel]  <= wrap_inc(r_head[i_sel]);
                    r_count[i_sel] <= r_count[i_sel] - 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == pfs_pkg::Q_PUSH) |-> (o_count < CW'(QUEUE_DEPTH)))
        else $error("push into a full run queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == pfs_pkg::Q_POP) |-> (o_count != '0))
        else $error("pop from an empty run queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op != pfs_pkg::Q_NOP) |=> (r_count[$past(i_sel)] <= CW'(QUEUE_DEPTH)))
        else $error("run queue count beyond depth");

endmodule

@@ rtl/per_cpu_fifo_scheduler_with_stealing_unit.sv @@
// Channel  Direction  Handshake                     Payload
// in       input      i_in_valid / o_in_ready       action, cpu, thread and tick flags
// out      output     o_out_valid / i_out_ready     outcome, picked thread, steal info
// cfg      input      i_cfg_valid / o_cfg_ready     active_cpus (3 bits)
//
// Insert and tick requests pass through the look-up state to the result; a get from the own
// queue also passes the pop and read-data states; a steal first scans one active CPU per
// step, since the single count comparator walks the per-CPU counts one at a time.
// The thread is read from a registered RAM, which adds a read-data state to every pop.
// Reset clears all queue pointers and counts at once and sets active_cpus to 4.
// Input is taken only while no request is in flight; a stalled result holds the block.
module per_cpu_fifo_scheduler_with_stealing_unit #(
    parameter int NUM_CPUS       = pfs_pkg::NUM_CPUS_DEF,
    parameter int QUEUE_DEPTH    = pfs_pkg::QUEUE_DEPTH_DEF,
    parameter int THREAD_ID_BITS = pfs_pkg::THREAD_ID_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [pfs_pkg::ACTION_W-1:0]  i_action,
    input  logic [pfs_pkg::CPU_W-1:0]     i_cpu,
    input  logic [THREAD_ID_BITS-1:0]     i_thread_id,
    input  logic                          i_thread_is_idle,
    input  logic                          i_has_current_thread,
    input  logic                          i_current_stopped,
    input  logic                          i_running_idle,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pfs_pkg::OUTCOME_W-1:0] o_outcome,
    output logic [THREAD_ID_BITS-1:0]     o_picked_thread,
    output logic                          o_stolen,
    output logic [pfs_pkg::VICTIM_W-1:0]  o_victim_cpu,
    output logic                          o_resched,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pfs_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int SEL_W  = $clog2(NUM_CPUS);
    localparam int PW     = $clog2(QUEUE_DEPTH);
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int NCW    = $clog2(NUM_CPUS + 1);
    localparam int AW     = (NCW > pfs_pkg::CFG_W) ? NCW : pfs_pkg::CFG_W;
    localparam int RAM_AW = SEL_W + PW;

    pfs_pkg::t_state   r_state, n_state;
    logic [pfs_pkg::CFG_W-1:0] r_active;
    pfs_pkg::t_action  r_action, n_action;
    logic [SEL_W-1:0]  r_sel, n_sel;
    logic [SEL_W-1:0]  r_cpu, n_cpu;
    logic [SEL_W-1:0]  r_best, n_best;
    logic [CW-1:0]     r_best_len, n_best_len;
    logic              r_found, n_found;
    logic [THREAD_ID_BITS-1:0] r_tid, n_tid;
    logic              r_idle, n_idle;
    logic              r_has_cur, n_has_cur;
    logic              r_stopped, n_stopped;
    logic              r_run_idle, n_run_idle;

    pfs_pkg::t_outcome r_outcome, n_outcome;
    logic [THREAD_ID_BITS-1:0] r_picked, n_picked;
    logic              r_stolen, n_stolen;
    logic [pfs_pkg::VICTIM_W-1:0] r_victim, n_victim;
    logic              r_resched, n_resched;

    pfs_pkg::t_q_op    q_op;
    logic [PW-1:0]     q_head;
    logic [PW-1:0]     q_tail;
    logic [CW-1:0]     q_count;

    logic              ram_we;
    logic [RAM_AW-1:0] ram_addr;
    logic [THREAD_ID_BITS-1:0] ram_rdata;

    logic [CW-1:0]     cmp_b;
    logic              cmp_gt;
    logic [AW-1:0]     act_ext;
    logic [AW-1:0]     act_eff;
    logic              act_multi;
    logic              scan_last;
    logic              cpu_ok;

    pfs_qtab #(
        .NUM_CPUS    (NUM_CPUS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_qtab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sel   (r_sel),
        .i_op    (q_op),
        .o_head  (q_head),
        .o_tail  (q_tail),
        .o_count (q_count)
    );

    pfs_ram #(
        .WIDTH (THREAD_ID_BITS),
        .DEPTH (2 ** RAM_AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (r_tid),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    assign ram_addr = {r_sel, (r_state == pfs_pkg::ST_POP) ? q_head : q_tail};

    // A register value above the CPU count acts as the CPU count.
    assign act_ext   = AW'(r_active);
    assign act_eff   = (act_ext > AW'(NUM_CPUS)) ? AW'(NUM_CPUS) : act_ext;
    assign act_multi = act_eff > AW'(1);
    assign scan_last = (AW'(r_sel) + AW'(1)) == act_eff;
    assign cpu_ok    = AW'(i_cpu) < AW'(NUM_CPUS);

    // One comparator serves the full check, the empty check and the steal scan.
    always_comb begin
        unique case (r_state)
            pfs_pkg::ST_LOOK: begin
                cmp_b = (r_action == pfs_pkg::ACT_INSERT) ? CW'(QUEUE_DEPTH - 1) : '0;
            end
            pfs_pkg::ST_SCAN: begin
                cmp_b = r_best_len;
            end
            default: begin
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_gt = q_count > cmp_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pfs_pkg::ST_IDLE;
            r_active <= pfs_pkg::ACTIVE_CPUS_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_active <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_sel      <= n_sel;
        r_cpu      <= n_cpu;
        r_best     <= n_best;
        r_best_len <= n_best_len;
        r_found    <= n_found;
        r_tid      <= n_tid;
        r_idle     <= n_idle;
        r_has_cur  <= n_has_cur;
        r_stopped  <= n_stopped;
        r_run_idle <= n_run_idle;
        r_outcome  <= n_outcome;
        r_picked   <= n_picked;
        r_stolen   <= n_stolen;
        r_victim   <= n_victim;
        r_resched  <= n_resched;
    end

    always_comb begin
        n_state    = r_state;
        n_action   = r_action;
        n_sel      = r_sel;
        n_cpu      = r_cpu;
        n_best     = r_best;
        n_best_len = r_best_len;
        n_found    = r_found;
        n_tid      = r_tid;
        n_idle     = r_idle;
        n_has_cur  = r_has_cur;
        n_stopped  = r_stopped;
        n_run_idle = r_run_idle;
        n_outcome  = r_outcome;
        n_picked   = r_picked;
        n_stolen   = r_stolen;
        n_victim   = r_victim;
        n_resched  = r_resched;
        q_op       = pfs_pkg::Q_NOP;
        ram_we     = 1'b0;

        unique case (r_state)
            pfs_pkg::ST_IDLE: begin
                n_action   = pfs_pkg::t_action'(i_action);
                n_sel      = SEL_W'(i_cpu);
                n_cpu      = SEL_W'(i_cpu);
                n_tid      = i_thread_id;
                n_idle     = i_thread_is_idle;
                n_has_cur  = i_has_current_thread;
                n_stopped  = i_current_stopped;
                n_run_idle = i_running_idle;
                n_picked   = '0;
                n_stolen   = 1'b0;
                n_victim   = '0;
                n_resched  = 1'b0;
                // Unused actions and absent CPUs are consumed without a result.
                if (i_in_valid && cpu_ok &&
                    (pfs_pkg::t_action'(i_action) != pfs_pkg::ACT_NONE)) begin
                    n_state = pfs_pkg::ST_LOOK;
                end
            end
            pfs_pkg::ST_LOOK: begin
                unique case (r_action)
                    pfs_pkg::ACT_INSERT: begin
                        n_state = pfs_pkg::ST_OUT;
                        if (r_idle) begin
                            n_outcome = pfs_pkg::OC_IDLE_IGNORE;
                        end else if (cmp_gt) begin
                            n_outcome = pfs_pkg::OC_DROPPED;
                        end else begin
                            ram_we    = 1'b1;
                            q_op      = pfs_pkg::Q_PUSH;
                            n_outcome = pfs_pkg::OC_QUEUED;
                        end
                    end
                    pfs_pkg::ACT_GET: begin
                        if (cmp_gt) begin
                            n_state = pfs_pkg::ST_POP;
                        end else if (act_multi) begin
                            n_sel      = '0;
                            n_best     = '0;
                            n_best_len = '0;
                            n_found    = 1'b0;
                            n_state    = pfs_pkg::ST_SCAN;
                        end else begin
                            n_outcome = pfs_pkg::OC_IDLE_PICKED;
                            n_state   = pfs_pkg::ST_OUT;
                        end
                    end
                    default: begin
                        n_outcome = pfs_pkg::OC_TICK_DONE;
                        n_resched = r_has_cur && !r_stopped && (r_run_idle || cmp_gt);
                        n_state   = pfs_pkg::ST_OUT;
                    end
                endcase
            end
            pfs_pkg::ST_SCAN: begin
                // Strictly greater keeps the lowest index on a tie.
                if (cmp_gt) begin
                    n_best_len = q_count;
                    n_best     = r_sel;
                    n_found    = 1'b1;
                end
                if (scan_last) begin
                    n_sel = cmp_gt ? r_sel : r_best;
                    if (r_found || cmp_gt) begin
                        n_state = pfs_pkg::ST_POP;
                    end else begin
                        n_outcome = pfs_pkg::OC_IDLE_PICKED;
                        n_state   = pfs_pkg::ST_OUT;
                    end
                end else begin
                    n_sel = r_sel + 1'b1;
                end
            end
            pfs_pkg::ST_POP: begin
                q_op     = pfs_pkg::Q_POP;
                n_stolen = r_sel != r_cpu;
                n_victim = (r_sel != r_cpu) ? pfs_pkg::VICTIM_W'(r_sel) : '0;
                n_state  = pfs_pkg::ST_RDATA;
            end
            pfs_pkg::ST_RDATA: begin
                n_picked  = ram_rdata;
                n_outcome = pfs_pkg::OC_PICKED;
                n_state   = pfs_pkg::ST_OUT;
            end
            pfs_pkg::ST_OUT: begin
                if (i_out_ready) begin
                    n_state = pfs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pfs_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_ready      = r_state == pfs_pkg::ST_IDLE;
    assign o_out_valid     = r_state == pfs_pkg::ST_OUT;
    assign o_outcome       = r_outcome;
    assign o_picked_thread = r_picked;
    assign o_stolen        = r_stolen;
    assign o_victim_cpu    = r_victim;
    assign o_resched       = r_resched;
    assign o_cfg_ready     = 1'b1;

    a_stolen_is_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stolen) |-> (o_outcome == pfs_pkg::OC_PICKED))
        else $error("steal reported without a picked thread");

    a_resched_is_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_resched) |-> (o_outcome == pfs_pkg::OC_TICK_DONE))
        else $error("reschedule reported outside a tick");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfs_pkg::ST_SCAN) |-> (AW'(r_sel) < act_eff))
        else $error("steal scan beyond the active CPUs");

    a_pop_has_thread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfs_pkg::ST_POP) |-> (q_count != '0))
        else $error("pop selected an empty queue");

endmodule
